/* rtl/byte_level_token_decoder_core_defines.svh */
// Assertion macros shared by the byte-level token decoder modules.
`ifndef BYTE_LEVEL_TOKEN_DECODER_CORE_DEFINES_SVH
`define BYTE_LEVEL_TOKEN_DECODER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define BLTD_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define BLTD_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define BLTD_ASSERT(lbl, clk, rstn, prop, msg)
`define BLTD_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif

`endif

/* rtl/bltd_pkg.sv */
// Types, constants and the code point unmapping function of the token decoder.
package bltd_pkg;

	localparam logic [7:0] CONT_MASK   = 8'h3F;
	localparam logic [7:0] LEAD2_MASK  = 8'h1F;
	localparam logic [7:0] LEAD3_MASK  = 8'h0F;
	localparam logic [7:0] TOP3_MASK   = 8'hE0;
	localparam logic [7:0] TOP4_MASK   = 8'hF0;
	localparam logic [7:0] LEAD2_TAG   = 8'hC0;
	localparam logic [7:0] LEAD3_TAG   = 8'hE0;
	localparam logic [7:0] ASCII_LIMIT = 8'h80;

	localparam logic [15:0] CP_PRINT_LO  = 16'd33;
	localparam logic [15:0] CP_PRINT_HI  = 16'd126;
	localparam logic [15:0] CP_LATIN_LO  = 16'd161;
	localparam logic [15:0] CP_LATIN_HI  = 16'd172;
	localparam logic [15:0] CP_UPPER_LO  = 16'd174;
	localparam logic [15:0] CP_UPPER_HI  = 16'd255;
	localparam logic [15:0] CP_CTRL_LO   = 16'd256;
	localparam logic [15:0] CP_CTRL_HI   = 16'd288;
	localparam logic [15:0] CP_HIGH_LO   = 16'd289;
	localparam logic [15:0] CP_HIGH_HI   = 16'd322;
	localparam logic [15:0] CP_HIGH_OFS  = 16'd162;
	localparam logic [15:0] CP_SHY       = 16'd323;
	localparam logic [7:0]  BYTE_SHY     = 8'd173;

	localparam logic [1:0] HELD_NONE = 2'd0;
	localparam logic [1:0] HELD_ONE  = 2'd1;
	localparam logic [1:0] HELD_TWO  = 2'd2;
	localparam logic [1:0] NEED_NONE = 2'd0;
	localparam logic [1:0] NEED_TWO  = 2'd2;
	localparam logic [1:0] NEED_THREE = 2'd3;

	typedef struct packed {
		logic       ok;
		logic [7:0] b;
	} unmap_t;

	// One decoded group: up to three result bytes, emitted lowest entry first.
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      count;
		logic            has;
		logic            tok_last;
	} grp_t;

	function automatic unmap_t unmap_cp(input logic [15:0] cp);
		unmap_t r;
		r.ok = 1'b1;
		r.b  = cp[7:0];
		if ((cp >= CP_PRINT_LO && cp <= CP_PRINT_HI) ||
		    (cp >= CP_LATIN_LO && cp <= CP_LATIN_HI) ||
		    (cp >= CP_UPPER_LO && cp <= CP_UPPER_HI)) begin
			r.b = cp[7:0];
		end else if (cp >= CP_CTRL_LO && cp <= CP_CTRL_HI) begin
			r.b = cp[7:0];
		end else if (cp >= CP_HIGH_LO && cp <= CP_HIGH_HI) begin
			r.b = 8'(cp - CP_HIGH_OFS);
		end else if (cp == CP_SHY) begin
			r.b = BYTE_SHY;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

/* rtl/bltd_decode.sv */
// Input register, sequence state and UTF-8 decode of one byte into a result group.
`include "byte_level_token_decoder_core_defines.svh"

module bltd_decode (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    s_tdata,
	input  logic          s_tlast,
	input  logic          grp_free,
	output logic          grp_load,
	output bltd_pkg::grp_t grp
);
	import bltd_pkg::*;

	logic       s1_vld_q;
	logic [7:0] byte_s1;
	logic       last_s1;

	logic [7:0] lead_q;
	logic [7:0] mid_q;
	logic [1:0] held_q;
	logic [1:0] need_q;

	logic [7:0] lead_d;
	logic [7:0] mid_d;
	logic [1:0] held_d;
	logic [1:0] need_d;

	logic            fin_c;
	logic [1:0]      len_c;
	logic [15:0]     cp_c;
	logic [2:0][7:0] raw_c;
	unmap_t          um_c;
	logic            emit_c;
	logic            advance;

	always_comb begin
		lead_d = lead_q;
		mid_d  = mid_q;
		held_d = held_q;
		need_d = need_q;
		fin_c  = 1'b0;
		len_c  = 2'd1;
		cp_c   = '0;
		raw_c  = '0;
		if (held_q == HELD_NONE) begin
			if (byte_s1 < ASCII_LIMIT) begin
				fin_c    = 1'b1;
				len_c    = 2'd1;
				cp_c     = {8'd0, byte_s1};
				raw_c[0] = byte_s1;
			end else if ((byte_s1 & TOP3_MASK) == LEAD2_TAG) begin
				lead_d = byte_s1;
				held_d = HELD_ONE;
				need_d = NEED_TWO;
			end else if ((byte_s1 & TOP4_MASK) == LEAD3_TAG) begin
				lead_d = byte_s1;
				held_d = HELD_ONE;
				need_d = NEED_THREE;
			end
		end else if (held_q == HELD_ONE && need_q == NEED_THREE) begin
			mid_d  = byte_s1;
			held_d = HELD_TWO;
		end else if (held_q == HELD_ONE) begin
			fin_c    = 1'b1;
			len_c    = 2'd2;
			cp_c     = {5'd0, lead_q[4:0] & LEAD2_MASK[4:0], byte_s1[5:0] & CONT_MASK[5:0]};
			raw_c[0] = lead_q;
			raw_c[1] = byte_s1;
			held_d   = HELD_NONE;
			need_d   = NEED_NONE;
		end else begin
			fin_c    = 1'b1;
			len_c    = 2'd3;
			cp_c     = {lead_q[3:0] & LEAD3_MASK[3:0], mid_q[5:0] & CONT_MASK[5:0],
			            byte_s1[5:0] & CONT_MASK[5:0]};
			raw_c[0] = lead_q;
			raw_c[1] = mid_q;
			raw_c[2] = byte_s1;
			held_d   = HELD_NONE;
			need_d   = NEED_NONE;
		end
		if (last_s1) begin
			lead_d = '0;
			mid_d  = '0;
			held_d = HELD_NONE;
			need_d = NEED_NONE;
		end
	end

	assign um_c = unmap_cp(cp_c);

	always_comb begin
		grp          = '0;
		grp.tok_last = last_s1;
		grp.has      = 1'b1;
		grp.count    = 2'd1;
		if (fin_c) begin
			if (um_c.ok) begin
				grp.bytes[0] = um_c.b;
			end else begin
				grp.bytes = raw_c;
				grp.count = len_c;
			end
		end else begin
			grp.has = 1'b0;
		end
	end

	assign emit_c   = fin_c || last_s1;
	assign advance  = s1_vld_q && (!emit_c || grp_free);
	assign grp_load = s1_vld_q && emit_c && grp_free;
	assign s_tready = !s1_vld_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
			held_q   <= HELD_NONE;
			need_q   <= NEED_NONE;
		end else begin
			if (s_tvalid && s_tready) begin
				s1_vld_q <= 1'b1;
			end else if (advance) begin
				s1_vld_q <= 1'b0;
			end
			if (advance) begin
				held_q <= held_d;
				need_q <= need_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
		if (advance) begin
			lead_q <= lead_d;
			mid_q  <= mid_d;
		end
	end

	`BLTD_ASSERT(a_two_held_three_needed, clk, arst_n, (held_q == HELD_TWO) |-> (need_q == NEED_THREE), "two bytes held outside a three-byte sequence")
	`BLTD_ASSERT(a_one_held_len, clk, arst_n, (held_q == HELD_ONE) |-> (need_q == NEED_TWO || need_q == NEED_THREE), "pending sequence without a valid length")
	`BLTD_ASSERT(a_idle_no_need, clk, arst_n, (held_q == HELD_NONE) |-> (need_q == NEED_NONE), "length set with no sequence pending")
	`BLTD_ASSERT_NEXT(a_last_clears, clk, arst_n, advance && last_s1, held_q == HELD_NONE, "sequence state survives the end of a token")

endmodule

/* rtl/bltd_emit.sv */
// Result group register and the stepper that hands its bytes out one request at a time.
`include "byte_level_token_decoder_core_defines.svh"

module bltd_emit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           grp_load,
	input  bltd_pkg::grp_t grp,
	output logic           grp_free,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [7:0]     m_tdata,
	output logic [1:0]     m_tuser,
	output logic           m_tlast
);
	import bltd_pkg::*;

	logic       vld_q;
	logic [1:0] idx_q;
	grp_t       grp_s2;
	logic       idx_last;

	assign idx_last = (idx_q == grp_s2.count - 2'd1);
	assign grp_free = !vld_q || (m_tready && idx_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (grp_load) begin
				vld_q <= 1'b1;
				idx_q <= '0;
			end else if (vld_q && m_tready) begin
				if (idx_last) begin
					vld_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (grp_load) begin
			grp_s2 <= grp;
		end
	end

	always_comb begin
		case (idx_q)
			2'd0:    m_tdata = grp_s2.bytes[0];
			2'd1:    m_tdata = grp_s2.bytes[1];
			2'd2:    m_tdata = grp_s2.bytes[2];
			default: m_tdata = '0;
		endcase
	end

	assign m_tvalid   = vld_q;
	assign m_tuser[0] = grp_s2.has;
	assign m_tuser[1] = idx_last;
	assign m_tlast    = idx_last && grp_s2.tok_last;

	`BLTD_ASSERT(a_idx_in_group, clk, arst_n, vld_q |-> (idx_q < grp_s2.count && grp_s2.count != 2'd0), "result index beyond the group")
	`BLTD_ASSERT(a_load_when_free, clk, arst_n, grp_load |-> grp_free, "group loaded over one still being sent")
	`BLTD_ASSERT(a_empty_is_token_end, clk, arst_n, (vld_q && !grp_s2.has) |-> (grp_s2.count == 2'd1 && grp_s2.tok_last), "empty result outside the end of a token")

endmodule

/* rtl/byte_level_token_decoder_core.sv */
// Top level of the byte-level token decoder: input stage with decode, then result stepper.
//
// Channel   Direction  Ports                    Contents
// s_*       in         tvalid tready tdata tlast  raw token byte, last byte of the token
// m_*       out        tvalid tready tdata tuser  decoded byte, has_byte and run_last flags
//                      tlast                      end of the token
//
// Each input byte passes through the decode stage into the result register, which steps out its results one at a time.
// A byte gives zero to three results; besides a stalled output, only a passthrough of two or
// three raw bytes holds the input back, while the result register steps through the group.
// One input byte can wait in the input register while the result register is stalled.
// Reset clears the valid flags and the pending sequence state.
module byte_level_token_decoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // in_byte[7:0]
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // out_byte[7:0]
	output logic [1:0] m_tuser,   // has_byte[0], run_last[1]
	output logic       m_tlast
);
	import bltd_pkg::*;

	logic grp_free;
	logic grp_load;
	grp_t grp;

	bltd_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.grp_free (grp_free),
		.grp_load (grp_load),
		.grp      (grp)
	);

	bltd_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.grp_load (grp_load),
		.grp      (grp),
		.grp_free (grp_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
